@@ src/assert_macros.svh @@
// assertion macros used by the core's top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/mrc_pkg.sv @@
// shared constants, codes and types of the mini risc core
package mrc_pkg;

	localparam int DATA_W         = 8;
	localparam int NUM_REGS       = 8;
	localparam int REG_AW         = $clog2(NUM_REGS);
	localparam int INSTR_W        = 16;
	localparam int ADDR_W         = 8;
	localparam int OP_W           = 2;
	localparam int IMM_W          = 6;
	localparam int IMEM_DEPTH_DEF = 256;
	localparam int DMEM_DEPTH_DEF = 256;

	// transaction operations
	localparam logic [OP_W-1:0] OP_EXEC   = 2'd0;
	localparam logic [OP_W-1:0] OP_IWRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_DWRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_DREAD  = 2'd3;

	// instruction opcodes
	localparam logic [3:0] OPC_RTYPE = 4'd0;
	localparam logic [3:0] OPC_J     = 4'd2;
	localparam logic [3:0] OPC_ADDI  = 4'd4;
	localparam logic [3:0] OPC_BEQ   = 4'd8;
	localparam logic [3:0] OPC_LW    = 4'd11;
	localparam logic [3:0] OPC_SW    = 4'd15;

	// r-type function codes
	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd2;
	localparam logic [2:0] FN_AND = 3'd4;
	localparam logic [2:0] FN_OR  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_RDATA,
		ST_DONE
	} mrc_state_t;

	// decoded and executed instruction
	typedef struct packed {
		logic              illegal;
		logic              halt;
		logic              reg_we;
		logic [REG_AW-1:0] reg_idx;
		logic [DATA_W-1:0] reg_val;
		logic              mem_we;
		logic              mem_re;
		logic              ovf;
		logic              br;
		logic [ADDR_W-1:0] ea;
		logic              pc_we;
		logic [ADDR_W-1:0] new_pc;
	} mrc_exec_t;

	// result fields apart from pc and halt
	typedef struct packed {
		logic              illegal;
		logic              reg_written;
		logic [REG_AW-1:0] reg_index;
		logic [DATA_W-1:0] reg_value;
		logic              mem_written;
		logic              overflow;
		logic              branch_taken;
		logic [DATA_W-1:0] read_data;
	} mrc_result_t;

endpackage

@@ src/mrc_regfile.sv @@
// register file: two registered read ports, one write port, reset to zero by valid bits
module mrc_regfile
	import mrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [REG_AW-1:0] raddr_a,
	input  logic [REG_AW-1:0] raddr_b,
	input  logic              we,
	input  logic [REG_AW-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0]   mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [DATA_W-1:0]   rd_a_q;
	logic [DATA_W-1:0]   rd_b_q;

	// storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// written marks, a register never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= valid_q[raddr_a] ? mem_q[raddr_a] : '0;
			rd_b_q <= valid_q[raddr_b] ? mem_q[raddr_b] : '0;
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ src/mrc_imem.sv @@
// instruction memory: 16-bit words, one write and one registered read port
module mrc_imem
	import mrc_pkg::*;
#(
	parameter int DEPTH = IMEM_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [INSTR_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [INSTR_W-1:0] rdata
);

	localparam int AW    = $clog2(DEPTH);
	localparam int TAB_N = 1 << ADDR_W;

	logic [INSTR_W-1:0] mem_q [DEPTH];
	logic [INSTR_W-1:0] rd_q;
	logic [AW-1:0]      idx_tab [TAB_N];

	// address folding onto the depth
	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		assign idx_tab[i] = AW'(i % DEPTH);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[idx_tab[waddr]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[idx_tab[raddr]];
		end
	end

	assign rdata = rd_q;

endmodule

@@ src/mrc_dmem.sv @@
// data memory: bytes, one write and one registered read port, zero until written
module mrc_dmem
	import mrc_pkg::*;
#(
	parameter int DEPTH = DMEM_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int AW    = $clog2(DEPTH);
	localparam int TAB_N = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_q;
	logic [AW-1:0]     idx_tab [TAB_N];
	logic [AW-1:0]     widx;
	logic [AW-1:0]     ridx;

	// address folding onto the depth
	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		assign idx_tab[i] = AW'(i % DEPTH);
	end

	assign widx = idx_tab[waddr];
	assign ridx = idx_tab[raddr];

	// storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[widx] <= wdata;
		end
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[widx] <= 1'b1;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= valid_q[ridx] ? mem_q[ridx] : '0;
		end
	end

	assign rdata = rd_q;

endmodule

@@ src/mrc_exec.sv @@
// instruction decode, alu and next pc
module mrc_exec
	import mrc_pkg::*;
(
	input  logic [INSTR_W-1:0] instr,
	input  logic [DATA_W-1:0]  rs_val,
	input  logic [DATA_W-1:0]  rt_val,
	input  logic [ADDR_W-1:0]  pc,
	output mrc_exec_t          ex
);

	logic [3:0]        opc;
	logic [REG_AW-1:0] rt;
	logic [REG_AW-1:0] rd;
	logic [2:0]        fn;
	logic [IMM_W-1:0]  imm;
	logic [DATA_W:0]   sum_rr;
	logic [DATA_W:0]   dif_rr;
	logic [DATA_W:0]   sum_ri;
	logic [ADDR_W-1:0] pc_inc;
	logic [ADDR_W-1:0] pc_br;

	assign opc = instr[15:12];
	assign rt  = instr[8:6];
	assign rd  = instr[5:3];
	assign fn  = instr[2:0];
	assign imm = instr[IMM_W-1:0];

	// sign-extended sums, one bit wider to see overflow
	assign sum_rr = {rs_val[DATA_W-1], rs_val} + {rt_val[DATA_W-1], rt_val};
	assign dif_rr = {rs_val[DATA_W-1], rs_val} - {rt_val[DATA_W-1], rt_val};
	assign sum_ri = {rs_val[DATA_W-1], rs_val} + {{(DATA_W+1-IMM_W){imm[IMM_W-1]}}, imm};

	assign pc_inc = pc + ADDR_W'(1);
	assign pc_br  = pc + {{(ADDR_W-IMM_W){imm[IMM_W-1]}}, imm} + ADDR_W'(1);

	always_comb begin
		ex        = '0;
		ex.new_pc = pc_inc;
		if (instr == '0) begin
			// halt word: pc stays
			ex.halt = 1'b1;
		end else begin
			case (opc)
				OPC_RTYPE: begin
					case (fn)
						FN_ADD: begin
							ex.reg_val = sum_rr[DATA_W-1:0];
							ex.ovf     = sum_rr[DATA_W] ^ sum_rr[DATA_W-1];
						end
						FN_SUB: begin
							ex.reg_val = dif_rr[DATA_W-1:0];
							ex.ovf     = dif_rr[DATA_W] ^ dif_rr[DATA_W-1];
						end
						FN_AND: ex.reg_val = rs_val & rt_val;
						FN_OR:  ex.reg_val = rs_val | rt_val;
						default: ex.illegal = 1'b1;
					endcase
					if (!ex.illegal) begin
						ex.reg_we  = 1'b1;
						ex.reg_idx = rd;
						ex.pc_we   = 1'b1;
					end
				end
				OPC_ADDI: begin
					ex.reg_we  = 1'b1;
					ex.reg_idx = rt;
					ex.reg_val = sum_ri[DATA_W-1:0];
					ex.ovf     = sum_ri[DATA_W] ^ sum_ri[DATA_W-1];
					ex.pc_we   = 1'b1;
				end
				OPC_LW: begin
					// register write follows the data read
					ex.mem_re  = 1'b1;
					ex.reg_idx = rt;
					ex.ea      = sum_ri[ADDR_W-1:0];
					ex.ovf     = sum_ri[DATA_W] ^ sum_ri[DATA_W-1];
					ex.pc_we   = 1'b1;
				end
				OPC_SW: begin
					ex.mem_we = 1'b1;
					ex.ea     = sum_ri[ADDR_W-1:0];
					ex.ovf    = sum_ri[DATA_W] ^ sum_ri[DATA_W-1];
					ex.pc_we  = 1'b1;
				end
				OPC_BEQ: begin
					ex.pc_we = 1'b1;
					if (rs_val == rt_val) begin
						ex.br     = 1'b1;
						ex.new_pc = pc_br;
					end
				end
				OPC_J: begin
					ex.br     = 1'b1;
					ex.pc_we  = 1'b1;
					ex.new_pc = instr[ADDR_W-1:0];
				end
				default: ex.illegal = 1'b1;
			endcase
		end
	end

endmodule

@@ src/mini_risc_8bit_single_cycle_core.sv @@
// top level of the mini risc core: sequencer, pc, halt flag and result register
//
// An 8-bit core with eight registers, a 16-bit instruction memory and a byte data
// memory. Each input transaction is one operation: execute the word at pc, write an
// instruction word, write a data byte or read a data byte; each gives exactly one
// result transaction. One transaction is worked on at a time: in_stall is high from
// the accepting edge until the result has moved into the output register, which then
// holds it for the consumer while the next transaction is already accepted. The
// result reaches the output register before the next acceptance. Writes go straight
// to the hand-off to the output register, a data read first reads the data memory,
// and an execute walks the chain of synchronous memory accesses: instruction fetch,
// register file read, execute and commit, and for lw the data memory read, then the
// hand-off; an execute while halted goes straight to the hand-off. An output stall
// holds back the hand-off.
// Register file and data memory read as zero after reset through per-entry written
// marks, so there is no clearing pass; instruction memory holds no defined contents
// until written.
`include "assert_macros.svh"

module mini_risc_8bit_single_cycle_core
	import mrc_pkg::*;
#(
	parameter int IMEM_DEPTH = IMEM_DEPTH_DEF,
	parameter int DMEM_DEPTH = DMEM_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [ADDR_W-1:0]   address,
	input  logic [INSTR_W-1:0]  write_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ADDR_W-1:0]   program_counter,
	output logic                halted,
	output logic                illegal,
	output logic                reg_written,
	output logic [REG_AW-1:0]   reg_index,
	output logic signed [DATA_W-1:0] reg_value,
	output logic                mem_written,
	output logic                overflow,
	output logic                branch_taken,
	output logic signed [DATA_W-1:0] read_data
);

	mrc_state_t        state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] pc_q;
	logic              halt_q;
	mrc_result_t       res_q, res_d;
	logic              res_load;
	mrc_result_t       out_q;
	logic [ADDR_W-1:0] out_pc_q;
	logic              out_halt_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;
	logic              out_load;
	logic              pc_we;
	logic              halt_set;

	logic               imem_we, imem_re;
	logic [INSTR_W-1:0] imem_rdata;
	logic               rf_re, rf_we;
	logic [REG_AW-1:0]  rf_waddr;
	logic [DATA_W-1:0]  rf_wdata, rf_rdata_a, rf_rdata_b;
	logic               dmem_we, dmem_re;
	logic [ADDR_W-1:0]  dmem_waddr, dmem_raddr;
	logic [DATA_W-1:0]  dmem_wdata, dmem_rdata;
	mrc_exec_t          ex;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// memories and execute unit
	mrc_imem #(.DEPTH(IMEM_DEPTH)) u_imem (
		.clk   (clk),
		.we    (imem_we),
		.waddr (address),
		.wdata (write_data),
		.re    (imem_re),
		.raddr (pc_q),
		.rdata (imem_rdata)
	);

	mrc_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (rf_re),
		.raddr_a (imem_rdata[11:9]),
		.raddr_b (imem_rdata[8:6]),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.rdata_a (rf_rdata_a),
		.rdata_b (rf_rdata_b)
	);

	mrc_dmem #(.DEPTH(DMEM_DEPTH)) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dmem_we),
		.waddr  (dmem_waddr),
		.wdata  (dmem_wdata),
		.re     (dmem_re),
		.raddr  (dmem_raddr),
		.rdata  (dmem_rdata)
	);

	mrc_exec u_exec (
		.instr  (imem_rdata),
		.rs_val (rf_rdata_a),
		.rt_val (rf_rdata_b),
		.pc     (pc_q),
		.ex     (ex)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_EXEC:  state_d = halt_q ? ST_DONE : ST_FETCH;
						OP_DREAD: state_d = ST_RDATA;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC:  state_d = ex.mem_re ? ST_RDATA : ST_DONE;
			ST_RDATA: state_d = ST_DONE;
			ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory strobes, commits and result assembly
	always_comb begin
		imem_we    = 1'b0;
		imem_re    = 1'b0;
		rf_re      = 1'b0;
		rf_we      = 1'b0;
		rf_waddr   = ex.reg_idx;
		rf_wdata   = ex.reg_val;
		dmem_we    = 1'b0;
		dmem_re    = 1'b0;
		dmem_waddr = ex.ea;
		dmem_raddr = ex.ea;
		dmem_wdata = rf_rdata_b;
		pc_we      = 1'b0;
		halt_set   = 1'b0;
		res_load   = 1'b0;
		res_d      = '0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_IWRITE: begin
							imem_we  = 1'b1;
							res_load = 1'b1;
						end
						OP_DWRITE: begin
							dmem_we    = 1'b1;
							dmem_waddr = address;
							dmem_wdata = write_data[DATA_W-1:0];
							res_load   = 1'b1;
						end
						OP_DREAD: begin
							dmem_re    = 1'b1;
							dmem_raddr = address;
						end
						default: begin
							// execute: fetch, or only an empty result once halted
							imem_re  = !halt_q;
							res_load = halt_q;
						end
					endcase
				end
			end
			ST_FETCH: rf_re = 1'b1;
			ST_EXEC: begin
				rf_we    = ex.reg_we;
				dmem_we  = ex.mem_we;
				dmem_re  = ex.mem_re;
				pc_we    = ex.pc_we;
				halt_set = ex.halt;
				res_load = !ex.mem_re;
				res_d.illegal      = ex.illegal;
				res_d.reg_written  = ex.reg_we;
				res_d.reg_index    = ex.reg_idx;
				res_d.reg_value    = ex.reg_val;
				res_d.mem_written  = ex.mem_we;
				res_d.overflow     = ex.ovf;
				res_d.branch_taken = ex.br;
			end
			ST_RDATA: begin
				res_load = 1'b1;
				if (op_q == OP_DREAD) begin
					res_d.read_data = dmem_rdata;
				end else begin
					// lw write-back
					rf_we             = 1'b1;
					rf_wdata          = dmem_rdata;
					res_d.reg_written = 1'b1;
					res_d.reg_index   = ex.reg_idx;
					res_d.reg_value   = dmem_rdata;
					res_d.overflow    = ex.ovf;
				end
			end
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pc_we) begin
				pc_q <= ex.new_pc;
			end
			if (halt_set) begin
				halt_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q      <= res_q;
			out_pc_q   <= pc_q;
			out_halt_q <= halt_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign program_counter = out_pc_q;
	assign halted          = out_halt_q;
	assign illegal         = out_q.illegal;
	assign reg_written     = out_q.reg_written;
	assign reg_index       = out_q.reg_index;
	assign reg_value       = out_q.reg_value;
	assign mem_written     = out_q.mem_written;
	assign overflow        = out_q.overflow;
	assign branch_taken    = out_q.branch_taken;
	assign read_data       = out_q.read_data;

	// checks
	`MRC_ASSERT_NOW(a_one_store, clk, arst_n, rf_we, !dmem_we, "register and data writes in one cycle")
	`MRC_ASSERT_NEXT(a_halt_holds_pc, clk, arst_n, halt_q, halt_q && $stable(pc_q), "pc moved while halted")
	`MRC_ASSERT_NOW(a_no_exec_halted, clk, arst_n, state_q == ST_EXEC, !halt_q, "instruction executed while halted")
	`MRC_ASSERT_NOW(a_illegal_quiet, clk, arst_n, state_q == ST_EXEC && ex.illegal, !rf_we && !dmem_we && !pc_we && !halt_set, "illegal instruction changed state")
	`MRC_ASSERT_NOW(a_rf_write_phase, clk, arst_n, rf_we, state_q == ST_EXEC || state_q == ST_RDATA, "register write outside execute")

endmodule

@@ bench/mini_risc_8bit_single_cycle_core_tb.sv @@
// self-checking testbench of the mini risc core: directed table, random programs, predictor
module mini_risc_8bit_single_cycle_core_tb
	import mrc_pkg::*;
;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 12;
	localparam int N_HEAD         = 26;
	localparam int N_ROWS         = 30;
	localparam int N_RANDOM       = 1520;
	localparam int CALM_FROM      = 700;
	localparam int CALM_TO        = 1000;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_SHOWN      = 10;
	localparam int VAL_MAX        = 127;
	localparam int VAL_MIN        = -128;

	localparam logic [INSTR_W-1:0] HALT_WORD = '0;
	localparam logic [2:0]         FN_BAD    = 3'd7;

	// one result transaction as the core reports it
	typedef struct packed {
		logic [ADDR_W-1:0] pc;
		logic              halted;
		logic              illegal;
		logic              reg_written;
		logic [REG_AW-1:0] reg_index;
		logic [DATA_W-1:0] reg_value;
		logic              mem_written;
		logic              overflow;
		logic              branch_taken;
		logic [DATA_W-1:0] read_data;
	} core_result_t;

	// directed row; fixed rows carry their expected pc, illegal and read data
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ADDR_W-1:0]  adr;
		logic [INSTR_W-1:0] wd;
		logic               at_pc;
		logic               fixed;
		logic [ADDR_W-1:0]  pc;
		logic               illegal;
		logic [DATA_W-1:0]  read_data;
	} stim_row_t;

	localparam stim_row_t DIR_ROWS [N_ROWS] = '{
		// data store reads zero after reset, then holds both byte extremes
		'{OP_DREAD,  8'd0,   16'h0000, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_DWRITE, 8'd0,   16'h007f, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_DWRITE, 8'd255, 16'hff80, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_DREAD,  8'd255, 16'h0000, 1'b0, 1'b1, 8'd0, 1'b0, 8'h80},
		// short program, all words placed before pc moves
		'{OP_IWRITE, 8'd0,   {OPC_LW, 3'd0, 3'd1, 6'h00}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd1,   {OPC_LW, 3'd0, 3'd2, 6'h3f}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd2,   {OPC_RTYPE, 3'd1, 3'd1, 3'd3, FN_ADD}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd3,   {OPC_RTYPE, 3'd2, 3'd1, 3'd4, FN_SUB}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd4,   {OPC_RTYPE, 3'd1, 3'd2, 3'd5, FN_AND}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd5,   {OPC_RTYPE, 3'd1, 3'd2, 3'd6, FN_OR},  1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd6,   {OPC_ADDI, 3'd1, 3'd7, 6'h1f}, 1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd7,   {OPC_SW, 3'd0, 3'd1, 6'h20},   1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd8,   {OPC_BEQ, 3'd1, 3'd1, 6'h01},  1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd10,  {OPC_J, 4'h0, 8'hff},          1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		'{OP_IWRITE, 8'd255, {OPC_RTYPE, 9'd0, FN_BAD},     1'b0, 1'b1, 8'd0, 1'b0, 8'h00},
		// lw 127, lw -128, add and sub overflow, and, or, addi overflow, sw, beq, j
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		// unknown funct at the top of the store: flagged, pc stays
		'{OP_EXEC, 8'd0, 16'h0000, 1'b0, 1'b1, 8'd255, 1'b1, 8'h00},
		// closing rows: halt word at pc, then the halted core ignores execution
		'{OP_IWRITE, 8'd0,   HALT_WORD, 1'b1, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC,   8'd0,   16'h0000,  1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_EXEC,   8'd0,   16'h0000,  1'b0, 1'b0, 8'd0, 1'b0, 8'h00},
		'{OP_DREAD,  8'd255, 16'h0000,  1'b0, 1'b0, 8'd0, 1'b0, 8'h00}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          operation;
	logic [ADDR_W-1:0]        address;
	logic [INSTR_W-1:0]       write_data;
	logic                     out_valid;
	logic                     out_stall;
	logic [ADDR_W-1:0]        program_counter;
	logic                     halted;
	logic                     illegal;
	logic                     reg_written;
	logic [REG_AW-1:0]        reg_index;
	logic signed [DATA_W-1:0] reg_value;
	logic                     mem_written;
	logic                     overflow;
	logic                     branch_taken;
	logic signed [DATA_W-1:0] read_data;

	// predicted core state
	logic [ADDR_W-1:0]  pc_q;
	logic               halt_q;
	logic               trap_q;
	logic [DATA_W-1:0]  regs_q [NUM_REGS];
	logic [INSTR_W-1:0] imem_q [IMEM_DEPTH_DEF];
	logic               imem_set [IMEM_DEPTH_DEF];
	logic [DATA_W-1:0]  dmem_q [DMEM_DEPTH_DEF];

	core_result_t pending_results [$];
	int           accepted_count = 0;
	int           fail_count     = 0;
	int           idle_cycles    = 0;

	mini_risc_8bit_single_cycle_core u_top (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic wraps(int s);
		return (s > VAL_MAX) || (s < VAL_MIN);
	endfunction

	function automatic logic calm_span();
		return (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);
	endfunction

	// next core state and result for one accepted input transaction
	function automatic core_result_t core_step(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] adr, input logic [INSTR_W-1:0] wd);
		core_result_t       r;
		logic [INSTR_W-1:0] word;
		logic [2:0]         rs, rt, rd;
		logic [ADDR_W-1:0]  imm8;
		int                 a, b, s;
		r = '0;
		word = imem_q[pc_q];
		rs = word[11:9];
		rt = word[8:6];
		rd = word[5:3];
		imm8 = {{2{word[5]}}, word[5:0]};
		a = int'($signed(regs_q[rs]));
		b = int'($signed(regs_q[rt]));
		case (op)
			OP_IWRITE: begin
				imem_q[adr] = wd;
				imem_set[adr] = 1'b1;
			end
			OP_DWRITE: dmem_q[adr] = wd[DATA_W-1:0];
			OP_DREAD: r.read_data = dmem_q[adr];
			default: if (!halt_q) begin
				if (word == HALT_WORD) begin
					halt_q = 1'b1;
				end else begin
					case (word[15:12])
						OPC_RTYPE: begin
							r.reg_written = 1'b1;
							r.reg_index = rd;
							case (word[2:0])
								FN_ADD: begin
									s = a + b;
									r.overflow = wraps(s);
									r.reg_value = s[DATA_W-1:0];
								end
								FN_SUB: begin
									s = a - b;
									r.overflow = wraps(s);
									r.reg_value = s[DATA_W-1:0];
								end
								FN_AND: r.reg_value = regs_q[rs] & regs_q[rt];
								FN_OR: r.reg_value = regs_q[rs] | regs_q[rt];
								default: begin
									r = '0;
									r.illegal = 1'b1;
								end
							endcase
							if (!r.illegal) begin
								regs_q[rd] = r.reg_value;
								pc_q = pc_q + 8'd1;
							end
						end
						OPC_ADDI: begin
							s = a + int'($signed(imm8));
							r.overflow = wraps(s);
							r.reg_written = 1'b1;
							r.reg_index = rt;
							r.reg_value = s[DATA_W-1:0];
							regs_q[rt] = r.reg_value;
							pc_q = pc_q + 8'd1;
						end
						OPC_LW, OPC_SW: begin
							s = a + int'($signed(imm8));
							r.overflow = wraps(s);
							if (word[15:12] == OPC_LW) begin
								r.reg_written = 1'b1;
								r.reg_index = rt;
								r.reg_value = dmem_q[s[ADDR_W-1:0]];
								regs_q[rt] = r.reg_value;
							end else begin
								dmem_q[s[ADDR_W-1:0]] = regs_q[rt];
								r.mem_written = 1'b1;
							end
							pc_q = pc_q + 8'd1;
						end
						OPC_BEQ: begin
							if (a == b) begin
								r.branch_taken = 1'b1;
								pc_q = pc_q + imm8 + 8'd1;
							end else begin
								pc_q = pc_q + 8'd1;
							end
						end
						OPC_J: begin
							r.branch_taken = 1'b1;
							pc_q = word[ADDR_W-1:0];
						end
						default: r.illegal = 1'b1;
					endcase
				end
				trap_q = r.illegal;
			end
		endcase
		r.pc = pc_q;
		r.halted = halt_q;
		return r;
	endfunction

	// random instruction word, mostly legal, never the halt word
	function automatic logic [INSTR_W-1:0] rand_instr();
		logic [INSTR_W-1:0] w;
		int                 k;
		w = INSTR_W'($urandom);
		k = $urandom_range(0, 19);
		if (k < 4) begin
			w[15:12] = OPC_RTYPE;
			case (k)
				0: w[2:0] = FN_ADD;
				1: w[2:0] = FN_SUB;
				2: w[2:0] = FN_AND;
				default: w[2:0] = FN_OR;
			endcase
		end else if (k < 7) begin
			w[15:12] = OPC_ADDI;
		end else if (k < 10) begin
			w[15:12] = OPC_LW;
		end else if (k < 12) begin
			w[15:12] = OPC_SW;
		end else if (k < 15) begin
			w[15:12] = OPC_BEQ;
		end else if (k < 17) begin
			w[15:12] = OPC_J;
		end
		// remaining draws keep the random opcode and funct
		if (w == HALT_WORD) begin
			w[0] = 1'b1;
		end
		return w;
	endfunction

	function automatic string show(core_result_t r);
		return $sformatf("pc=%0d halt=%0b ill=%0b rw=%0b ridx=%0d rval=%0d mw=%0b ovf=%0b br=%0b rdata=%0d",
			r.pc, r.halted, r.illegal, r.reg_written, r.reg_index, $signed(r.reg_value),
			r.mem_written, r.overflow, r.branch_taken, $signed(r.read_data));
	endfunction

	// offer one input transaction, starting at a rising edge; returns at its accepting edge
	task automatic send_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] adr,
			input logic [INSTR_W-1:0] wd, input logic fixed, input core_result_t fixed_res);
		int           gap;
		core_result_t res;
		gap = 0;
		if (!calm_span() && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 4);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= adr;
		write_data <= wd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		res = core_step(op, adr, wd);
		pending_results.push_back(fixed ? fixed_res : res);
		accepted_count++;
	endtask

	task automatic play_rows(input int first, input int last);
		stim_row_t    row;
		core_result_t want;
		for (int i = first; i < last; i++) begin
			row = DIR_ROWS[i];
			want = '0;
			want.pc = row.pc;
			want.illegal = row.illegal;
			want.read_data = row.read_data;
			send_op(row.op, row.at_pc ? pc_q : row.adr, row.wd, row.fixed, want);
		end
	endtask

	// reset, directed rows, random programs, drain and verdict
	initial begin : stimulus
		int                pick;
		logic [ADDR_W-1:0] adr;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_EXEC;
		address <= '0;
		write_data <= '0;
		pc_q = '0;
		halt_q = 1'b0;
		trap_q = 1'b0;
		foreach (regs_q[i]) regs_q[i] = '0;
		foreach (imem_q[i]) begin
			imem_q[i] = '0;
			imem_set[i] = 1'b0;
		end
		foreach (dmem_q[i]) dmem_q[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		play_rows(0, N_HEAD);

		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// execute, placing a fresh word first where pc has none or is stuck
				if (!imem_set[pc_q] || (trap_q && $urandom_range(0, 2) != 0)) begin
					send_op(OP_IWRITE, pc_q, rand_instr(), 1'b0, '0);
				end else begin
					send_op(OP_EXEC, ADDR_W'($urandom), INSTR_W'($urandom), 1'b0, '0);
				end
			end else if (pick < 80) begin
				if ($urandom_range(0, 9) < 7) begin
					adr = pc_q + ADDR_W'($urandom_range(0, 7));
				end else begin
					adr = ADDR_W'($urandom);
				end
				send_op(OP_IWRITE, adr, rand_instr(), 1'b0, '0);
			end else if (pick < 90) begin
				send_op(OP_DWRITE, ADDR_W'($urandom), INSTR_W'($urandom), 1'b0, '0);
			end else begin
				send_op(OP_DREAD, ADDR_W'($urandom), INSTR_W'($urandom), 1'b0, '0);
			end
		end

		play_rows(N_HEAD, N_ROWS);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("mini_risc_8bit_single_cycle_core_tb: done, clean");
		end else begin
			$display("mini_risc_8bit_single_cycle_core_tb: done, errors");
		end
		$finish;
	end

	// result side: sparse random stalls, one long hold-off, a calm stretch
	initial begin : receiver
		int   hold_left;
		logic held;
		hold_left = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && accepted_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm_span() && ($urandom_range(0, 99) < 10);
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		core_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{program_counter, halted, illegal, reg_written, reg_index, reg_value,
				mem_written, overflow, branch_taken, read_data};
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN) begin
					$display("result with nothing expected: %s", show(got));
				end
			end else begin
				want = pending_results.pop_front();
				if (got.pc !== want.pc || got.halted !== want.halted
						|| got.illegal !== want.illegal || got.reg_written !== want.reg_written
						|| got.reg_index !== want.reg_index || got.reg_value !== want.reg_value
						|| got.mem_written !== want.mem_written || got.overflow !== want.overflow
						|| got.branch_taken !== want.branch_taken
						|| got.read_data !== want.read_data) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("mismatch at %0t: expected %s", $time, show(want));
						$display("                 actual   %s", show(got));
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mini_risc_8bit_single_cycle_core_tb: done, errors");
			$finish;
		end
	end

endmodule
